FILE: rtl/core/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg
// Shared widths, constants and register map of the comparator edge divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ced_pkg;

  localparam int SAMPLE_BITS  = 15;
  localparam int MAX_DIVISION = 31;

  localparam int GAIN_W   = 17;
  localparam int OFFSET_W = 14;
  localparam int BASE_W   = 5;
  localparam int PLEN_W   = 16;
  localparam int STEP_W   = 5;

  localparam int UNIT_SHIFT  = 25;
  localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
  localparam int BASE_TERM_W = BASE_W + UNIT_SHIFT + 1;
  localparam int TOT_W       = ((PROD_W > BASE_TERM_W) ? PROD_W : BASE_TERM_W) + 1;
  localparam int QUO_W       = TOT_W - UNIT_SHIFT;
  localparam int CMP_W       = ((PROD_W > OFFSET_W + 16) ? PROD_W : OFFSET_W + 16) + 1;
  localparam int N_W         = $clog2(MAX_DIVISION + 1);
  localparam int CNT_W       = N_W;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_PLUS_GAIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SENSE_OFFSET = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIVIDE_BASE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CV_GAIN      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_LENGTH = 3'd4;

  localparam logic [GAIN_W-1:0]          PLUS_GAIN_RST    = '0;
  localparam logic signed [OFFSET_W-1:0] SENSE_OFFSET_RST = '0;
  localparam logic [BASE_W-1:0]          DIVIDE_BASE_RST  = 5'd1;
  localparam logic [GAIN_W-1:0]          CV_GAIN_RST      = '0;
  localparam logic [PLEN_W-1:0]          PULSE_LENGTH_RST = 16'd48;

endpackage

FILE: rtl/core/ced_in_if.sv
// ----------------------------------------------------------------------------
// ced_in_if
// Sample channel: plus, minus and division CV with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ced_in_if;

  logic                                 valid;
  logic                                 ready;
  logic signed [ced_pkg::SAMPLE_BITS-1:0] plus_sample;
  logic signed [ced_pkg::SAMPLE_BITS-1:0] minus_sample;
  logic signed [ced_pkg::SAMPLE_BITS-1:0] ratio_cv;

  modport source (output valid, output plus_sample, output minus_sample, output ratio_cv,
                  input ready);
  modport sink   (input valid, input plus_sample, input minus_sample, input ratio_cv,
                  output ready);

endinterface

FILE: rtl/core/ced_out_if.sv
// ----------------------------------------------------------------------------
// ced_out_if
// Result channel: comparator gate, divided gate and step index with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ced_out_if;

  logic                          valid;
  logic                          ready;
  logic                          compare_gate;
  logic                          divided_gate;
  logic [ced_pkg::STEP_W-1:0]    step_index;

  modport source (output valid, output compare_gate, output divided_gate, output step_index,
                  input ready);
  modport sink   (input valid, input compare_gate, input divided_gate, input step_index,
                  output ready);

endinterface

FILE: rtl/core/comparator_edge_divider_top.sv
// ----------------------------------------------------------------------------
// comparator_edge_divider_top
// An accepted item passes the input, product and result registers before its
// result is valid; throughput one item per cycle, stalls only on output.
// Reset is asynchronous active low: pipeline empty, edge memory high, count
// and pulse zero, registers at 0, 0, 1, 0, 48.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module comparator_edge_divider_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ced_in_if.sink                       in_i,
  ced_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ced_pkg::ADDR_W-1:0]   paddr,
  input  logic [ced_pkg::DATA_W-1:0]   pwdata,
  output logic [ced_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam logic signed [ced_pkg::TOT_W-1:0] Unit =
    ced_pkg::TOT_W'(1) << ced_pkg::UNIT_SHIFT;

  // configuration
  logic [ced_pkg::GAIN_W-1:0]          plus_gain_q;
  logic signed [ced_pkg::OFFSET_W-1:0] sense_offset_q;
  logic [ced_pkg::BASE_W-1:0]          divide_base_q;
  logic [ced_pkg::GAIN_W-1:0]          cv_gain_q;
  logic [ced_pkg::PLEN_W-1:0]          pulse_length_q;
  logic                                wr_en;
  logic [ced_pkg::REG_IDX_W-1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ced_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_gain_q    <= ced_pkg::PLUS_GAIN_RST;
      sense_offset_q <= ced_pkg::SENSE_OFFSET_RST;
      divide_base_q  <= ced_pkg::DIVIDE_BASE_RST;
      cv_gain_q      <= ced_pkg::CV_GAIN_RST;
      pulse_length_q <= ced_pkg::PULSE_LENGTH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ced_pkg::REG_PLUS_GAIN:    plus_gain_q    <= pwdata[ced_pkg::GAIN_W-1:0];
        ced_pkg::REG_SENSE_OFFSET: sense_offset_q <= $signed(pwdata[ced_pkg::OFFSET_W-1:0]);
        ced_pkg::REG_DIVIDE_BASE:  divide_base_q  <= pwdata[ced_pkg::BASE_W-1:0];
        ced_pkg::REG_CV_GAIN:      cv_gain_q      <= pwdata[ced_pkg::GAIN_W-1:0];
        ced_pkg::REG_PULSE_LENGTH: pulse_length_q <= pwdata[ced_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ced_pkg::REG_PLUS_GAIN:    prdata = ced_pkg::DATA_W'(plus_gain_q);
      ced_pkg::REG_SENSE_OFFSET: prdata = ced_pkg::DATA_W'($unsigned(sense_offset_q));
      ced_pkg::REG_DIVIDE_BASE:  prdata = ced_pkg::DATA_W'(divide_base_q);
      ced_pkg::REG_CV_GAIN:      prdata = ced_pkg::DATA_W'(cv_gain_q);
      ced_pkg::REG_PULSE_LENGTH: prdata = ced_pkg::DATA_W'(pulse_length_q);
      default:                   prdata = '0;
    endcase
  end

  // pipeline control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_free, s2_free, out_free;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_i.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // input register
  logic signed [ced_pkg::SAMPLE_BITS-1:0] s1_plus_q, s1_minus_q, s1_cv_q;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_free) begin
      s1_plus_q  <= in_i.plus_sample;
      s1_minus_q <= in_i.minus_sample;
      s1_cv_q    <= in_i.ratio_cv;
    end
  end

  // product register
  logic signed [ced_pkg::PROD_W-1:0]      plus_prod, cv_prod;
  logic signed [ced_pkg::PROD_W-1:0]      s2_plus_prod_q, s2_cv_prod_q;
  logic signed [ced_pkg::SAMPLE_BITS-1:0] s2_minus_q;

  assign plus_prod = s1_plus_q * $signed({1'b0, plus_gain_q});
  assign cv_prod   = s1_cv_q * $signed({1'b0, cv_gain_q});

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_free) begin
      s2_plus_prod_q <= plus_prod;
      s2_cv_prod_q   <= cv_prod;
      s2_minus_q     <= s1_minus_q;
    end
  end

  // gate and ratio
  logic signed [ced_pkg::CMP_W-1:0] lhs, rhs;
  logic signed [ced_pkg::TOT_W-1:0] total;
  logic [ced_pkg::QUO_W-1:0]        quo;
  logic [ced_pkg::N_W-1:0]          ratio;
  logic                             gate;

  assign lhs  = ced_pkg::CMP_W'(s2_plus_prod_q) + (ced_pkg::CMP_W'(sense_offset_q) <<< 16);
  assign rhs  = ced_pkg::CMP_W'(s2_minus_q) <<< 16;
  assign gate = lhs > rhs;

  assign total = (ced_pkg::TOT_W'($signed({1'b0, divide_base_q})) <<< ced_pkg::UNIT_SHIFT)
               + ced_pkg::TOT_W'(s2_cv_prod_q);
  assign quo   = $unsigned(total[ced_pkg::TOT_W-1:ced_pkg::UNIT_SHIFT]);

  always_comb begin
    if (total < Unit) begin
      ratio = ced_pkg::N_W'(1);
    end else if (quo > ced_pkg::QUO_W'(ced_pkg::MAX_DIVISION)) begin
      ratio = ced_pkg::N_W'(ced_pkg::MAX_DIVISION);
    end else begin
      ratio = ced_pkg::N_W'(quo);
    end
  end

  // edge counter and pulse stretcher
  logic                        prev_gate_q, prev_gate_d;
  logic [ced_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [ced_pkg::PLEN_W-1:0]  rem_q, rem_d, rem_fire;
  logic [ced_pkg::CNT_W:0]     cnt_inc;
  logic                        rising, wrap, div_gate;

  assign rising  = gate && !prev_gate_q;
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;
  assign wrap    = rising && (cnt_inc >= (ced_pkg::CNT_W + 1)'(ratio));

  always_comb begin
    prev_gate_d = gate;
    if (wrap) begin
      cnt_d = '0;
    end else if (rising) begin
      cnt_d = cnt_inc[ced_pkg::CNT_W-1:0];
    end else begin
      cnt_d = cnt_q;
    end
    rem_fire = (wrap && (pulse_length_q > rem_q)) ? pulse_length_q : rem_q;
    div_gate = rem_fire != '0;
    rem_d    = div_gate ? rem_fire - 1'b1 : rem_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_gate_q <= 1'b1;
      cnt_q       <= '0;
      rem_q       <= '0;
    end else if (s2_valid_q && out_free) begin
      prev_gate_q <= prev_gate_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
    end
  end

  // result register
  logic                       out_cmp_q, out_div_q;
  logic [ced_pkg::STEP_W-1:0] out_step_q;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_free) begin
      out_cmp_q  <= gate;
      out_div_q  <= div_gate;
      out_step_q <= ced_pkg::STEP_W'(cnt_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.compare_gate = out_cmp_q;
  assign out_o.divided_gate = out_div_q;
  assign out_o.step_index   = out_step_q;

endmodule

FILE: rtl/core/ced_checker.sv
// ----------------------------------------------------------------------------
// ced_checker
// Port-level checks on the comparator edge divider, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ced_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       compare_gate_i,
  input logic                       divided_gate_i,
  input logic [ced_pkg::STEP_W-1:0] step_index_i,
  input logic                       pready_i
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready low");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid straight after reset");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with output register empty");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(compare_gate_i)
      && $stable(divided_gate_i) && $stable(step_index_i))
    else $error("stalled result changed");

endmodule

bind comparator_edge_divider_top ced_checker u_ced_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .compare_gate_i (out_o.compare_gate),
  .divided_gate_i (out_o.divided_gate),
  .step_index_i   (out_o.step_index),
  .pready_i       (pready)
);
